// ----- hdl/assert_macros.svh -----
// assertion macros shared by the register file rtl
// expects signals named clock and reset in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/brfi_pkg.sv -----
// shared constants, types and helper functions of the banked register file
// no dependencies
package brfi_pkg;

   localparam int BANK_DEPTH = 64;
   localparam int RAM_DEPTH  = 2 * BANK_DEPTH;
   localparam int RAM_AW     = $clog2(RAM_DEPTH);

   typedef logic [RAM_AW-1:0] ram_addr_type;
   typedef logic [7:0]        byte_type;
   typedef logic [8:0]        ratio_type;

   // request codes
   localparam logic [2:0] REQ_READ   = 3'd0;
   localparam logic [2:0] REQ_WRITE  = 3'd1;
   localparam logic [2:0] REQ_STATUS = 3'd2;
   localparam logic [2:0] REQ_INTCON = 3'd3;
   localparam logic [2:0] REQ_OPTION = 3'd4;

   // special register offsets
   localparam byte_type OFS_INDIRECT = 8'h00;
   localparam byte_type OFS_OPTION   = 8'h01;
   localparam byte_type OFS_STATUS   = 8'h03;
   localparam byte_type OFS_FSR      = 8'h04;
   localparam byte_type OFS_INTCON   = 8'h0B;

   localparam int RP0_BIT      = 5;
   localparam int PSA_BIT      = 3;
   localparam int FSR_BANK_BIT = 7;

   localparam ratio_type PRESCALE_RESET = 9'd2;

   function automatic ratio_type prescale_decode(input logic [2:0] sel, input logic psa);
      ratio_type ratio;
      if (psa) begin
         ratio = 9'd1 << sel;
      end else begin
         ratio = 9'd2 << sel;
      end
      return ratio;
   endfunction

   function automatic byte_type apply_bits(input byte_type value, input byte_type mask,
                                           input logic set);
      byte_type result;
      if (set) begin
         result = value | mask;
      end else begin
         result = value & ~mask;
      end
      return result;
   endfunction

endpackage

// ----- hdl/brfi_req_if.sv -----
// request channel of the banked register file: valid/ready plus request payload
// no dependencies
interface brfi_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [7:0] reg_addr;
   logic [7:0] write_data;
   logic [7:0] bit_mask;
   logic       bit_value;

   modport source (
      output valid, req_type, reg_addr, write_data, bit_mask, bit_value,
      input  ready
   );
   modport sink (
      input  valid, req_type, reg_addr, write_data, bit_mask, bit_value,
      output ready
   );
endinterface

// ----- hdl/brfi_rsp_if.sv -----
// response channel of the banked register file: valid/ready plus result payload
// no dependencies
interface brfi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [7:0] status_byte;
   logic [7:0] intcon_byte;
   logic [7:0] option_byte;
   logic [8:0] prescale_ratio;

   modport source (
      output valid, read_data, status_byte, intcon_byte, option_byte, prescale_ratio,
      input  ready
   );
   modport sink (
      input  valid, read_data, status_byte, intcon_byte, option_byte, prescale_ratio,
      output ready
   );
endinterface

// ----- hdl/brfi_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module brfi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/banked_register_file_indirect_unit.sv -----
// Two-bank byte register file with indirect access through FSR and a timer prescale
// ratio. Each request beat is accepted, then makes one access to the synchronous
// register RAM (registered read data), then the response beat is loaded into the
// output register; the next request is accepted once that register is free or being
// taken. STATUS, FSR, INTCON and OPTION live in flops next to the RAM; RAM entries
// carry valid bits cleared by reset, so no clearing pass is needed after reset.
// depends on brfi_pkg, brfi_req_if, brfi_rsp_if, brfi_ram and assert_macros.svh
`include "assert_macros.svh"

module banked_register_file_indirect_unit
   import brfi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   brfi_req_if.sink      req_bus,
   brfi_rsp_if.source    rsp_bus
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0]     state_ff, state_in;

   logic [2:0]     op_ff;
   byte_type       addr_ff, data_ff, mask_ff;
   logic           val_ff;

   byte_type       status_ff, status_in;
   byte_type       fsr0_ff, fsr0_in, fsr1_ff, fsr1_in;
   byte_type       intcon0_ff, intcon0_in, intcon1_ff, intcon1_in;
   byte_type       option_ff, option_in;
   ratio_type      prescale_ff, prescale_in;
   logic [RAM_DEPTH-1:0] valid_ff, valid_in;

   logic           use_ram_ff, use_ram_in;
   logic           hit_ff, hit_in;
   byte_type       spec_ff, spec_in;

   logic           rsp_valid_ff, rsp_valid_in;
   byte_type       rsp_read_ff, rsp_status_ff, rsp_intcon_ff, rsp_option_ff;
   ratio_type      rsp_ratio_ff;

   logic           accept;
   logic           rp0;
   byte_type       cur_fsr;
   logic           indirect;
   logic           bank;
   byte_type       ofs;
   logic           in_range;
   ram_addr_type   ram_addr;
   logic           ram_we;
   byte_type       ram_q;
   byte_type       intcon_bits;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !reset && (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);

   // address resolution
   assign rp0      = status_ff[RP0_BIT];
   assign cur_fsr  = rp0 ? fsr1_ff : fsr0_ff;
   assign indirect = (addr_ff == OFS_INDIRECT);
   assign bank     = indirect ? cur_fsr[FSR_BANK_BIT] : rp0;
   assign ofs      = indirect ? {1'b0, cur_fsr[6:0]} : addr_ff;
   assign in_range = ({1'b0, ofs} < 9'(BANK_DEPTH));
   assign ram_addr = bank ? RAM_AW'(ofs) + RAM_AW'(BANK_DEPTH) : RAM_AW'(ofs);

   assign ram_we = (state_ff == S_EXEC) && (op_ff == REQ_WRITE) && in_range
                   && (ofs != OFS_STATUS);
   assign intcon_bits = apply_bits(intcon0_ff, mask_ff, val_ff);

   brfi_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (data_ff),
      .rd_en   (state_ff == S_EXEC),
      .rd_addr (ram_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      fsr0_in      = fsr0_ff;
      fsr1_in      = fsr1_ff;
      intcon0_in   = intcon0_ff;
      intcon1_in   = intcon1_ff;
      option_in    = option_ff;
      prescale_in  = prescale_ff;
      valid_in     = valid_ff;
      use_ram_in   = use_ram_ff;
      hit_in       = hit_ff;
      spec_in      = spec_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in   = S_RESP;
            use_ram_in = 1'b0;
            hit_in     = valid_ff[ram_addr];
            spec_in    = 8'h00;
            unique case (op_ff)
               REQ_READ: begin
                  if (in_range) begin
                     if (ofs == OFS_STATUS) begin
                        spec_in = status_ff;
                     end else if (ofs == OFS_FSR) begin
                        spec_in = bank ? fsr1_ff : fsr0_ff;
                     end else if (ofs == OFS_INTCON) begin
                        spec_in = bank ? intcon1_ff : intcon0_ff;
                     end else if (ofs == OFS_OPTION && bank) begin
                        spec_in = option_ff;
                     end else begin
                        use_ram_in = 1'b1;
                     end
                  end
               end
               REQ_WRITE: begin
                  // tmr0 write reloads the ratio from the current option
                  if (ofs == OFS_OPTION && !rp0) begin
                     prescale_in = prescale_decode(option_ff[2:0], option_ff[PSA_BIT]);
                  end
                  if (ofs == OFS_STATUS) begin
                     status_in = data_ff;
                  end else if (in_range) begin
                     valid_in[ram_addr] = 1'b1;
                     if (ofs == OFS_FSR) begin
                        if (bank) begin
                           fsr1_in = data_ff;
                        end else begin
                           fsr0_in = data_ff;
                        end
                     end
                     if (ofs == OFS_INTCON) begin
                        if (bank) begin
                           intcon1_in = data_ff;
                        end else begin
                           intcon0_in = data_ff;
                        end
                     end
                     if (ofs == OFS_OPTION && bank) begin
                        option_in = data_ff;
                        if (rp0 && (option_ff[1:0] != data_ff[1:0])) begin
                           prescale_in = prescale_decode({1'b0, data_ff[1:0]},
                                                         data_ff[PSA_BIT]);
                        end
                     end
                  end
               end
               REQ_STATUS: begin
                  status_in = apply_bits(status_ff, mask_ff, val_ff);
               end
               REQ_INTCON: begin
                  intcon0_in = intcon_bits;
                  intcon1_in = intcon_bits;
               end
               REQ_OPTION: begin
                  option_in = apply_bits(option_ff, mask_ff, val_ff);
               end
               default: begin
               end
            endcase
         end
         S_RESP: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= 8'h00;
         fsr0_ff      <= 8'h00;
         fsr1_ff      <= 8'h00;
         intcon0_ff   <= 8'h00;
         intcon1_ff   <= 8'h00;
         option_ff    <= 8'h00;
         prescale_ff  <= PRESCALE_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         fsr0_ff      <= fsr0_in;
         fsr1_ff      <= fsr1_in;
         intcon0_ff   <= intcon0_in;
         intcon1_ff   <= intcon1_in;
         option_ff    <= option_in;
         prescale_ff  <= prescale_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      use_ram_ff <= use_ram_in;
      hit_ff     <= hit_in;
      spec_ff    <= spec_in;
      if (accept) begin
         op_ff   <= req_bus.req_type;
         addr_ff <= req_bus.reg_addr;
         data_ff <= req_bus.write_data;
         mask_ff <= req_bus.bit_mask;
         val_ff  <= req_bus.bit_value;
      end
      if (state_ff == S_RESP) begin
         rsp_read_ff   <= use_ram_ff ? (hit_ff ? ram_q : 8'h00) : spec_ff;
         rsp_status_ff <= status_ff;
         rsp_intcon_ff <= status_ff[RP0_BIT] ? intcon1_ff : intcon0_ff;
         rsp_option_ff <= option_ff;
         rsp_ratio_ff  <= prescale_ff;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.read_data      = rsp_read_ff;
   assign rsp_bus.status_byte    = rsp_status_ff;
   assign rsp_bus.intcon_byte    = rsp_intcon_ff;
   assign rsp_bus.option_byte    = rsp_option_ff;
   assign rsp_bus.prescale_ratio = rsp_ratio_ff;

   `ASSERT_NEXT(a_accept_exec, accept, state_ff == S_EXEC, "accepted beat did not start access")
   `ASSERT_NEXT(a_resp_valid, state_ff == S_RESP, rsp_valid_ff, "response beat not presented")
   `ASSERT_SAME(a_slot_free, state_ff == S_RESP, !rsp_valid_ff, "response slot still occupied")
   `ASSERT_SAME(a_ratio_pow2, 1'b1, $onehot(prescale_ff), "prescale ratio not a power of two")

endmodule
